@@ sv/mpsl_pkg.sv @@
package mpsl_pkg;

  localparam int MAX_POWER_DEF = 16;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [2:0] REG_POW  = 3'd0;
  localparam logic [2:0] REG_XMIN = 3'd1;
  localparam logic [2:0] REG_XMAX = 3'd2;
  localparam logic [2:0] REG_YMIN = 3'd3;
  localparam logic [2:0] REG_YMAX = 3'd4;
  localparam logic [2:0] REG_ZMIN = 3'd5;
  localparam logic [2:0] REG_ZMAX = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_MAG,
    ST_POW,
    ST_ACC,
    ST_LOGK,
    ST_LOGSQ,
    ST_LOGMUL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MOP_SQ,
    MOP_Q16,
    MOP_LOGSQ,
    MOP_LN2
  } mop_t;

endpackage

@@ sv/mpsl_mul.sv @@
module mpsl_mul
  import mpsl_pkg::*;
(
  input  logic         clk,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [1:0]   step_r, step_nxt;
  logic         busy_r, busy_nxt;
  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r, acc_nxt;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;

  always_comb begin
    pa = step_r[0] ? a_r[63:32] : a_r[31:0];
    pb = step_r[1] ? b_r[63:32] : b_r[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt  = acc_r + ({64'd0, pp} << {{1'b0, step_r[1]} + {1'b0, step_r[0]}, 5'd0});
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    busy_r <= busy_nxt;
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    done   <= busy_r && (step_r == 2'd3) && !start;
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
  end

  assign prod = acc_r;

endmodule

@@ sv/masked_power_sum_log.sv @@
// masked_power_sum_log
// Input channel in_*: one dipole per transfer (valid/ready).
// Config port cfg_*: write enable, index, 16-bit data; write only while idle.
// Output channel out_*: one result per item with last set (valid/ready).
// Each item is processed by one shared 32x32 multiplier (four partial
// products per 64x64 product, with start and done) under a sequencer, plus a
// bit-pair square root unit.
// An in-box item costs two squarings per operand, two roots, one magnitude
// product and up to n power products (fewer once a term saturates), n being
// pow_num clamped to 1..MAX_POWER; an item outside the box skips all of these.
// A last item adds the log (normalisation, bitwise squarings and a multiply by
// ln2), skipped when the sum is not positive. in_ready is low from acceptance
// of an in-box or last item until it is done and its result (if any) taken.
// Reset clears the sum, saturation flag and registers (pow_num to 2).
// While out_ready is low the result holds and no item is taken.
module masked_power_sum_log
  import mpsl_pkg::*;
#(
  parameter int MAX_POWER = MAX_POWER_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic               in_clear,
  input  logic               in_last,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_coord_z,
  input  logic signed [31:0] in_pol_re,
  input  logic signed [31:0] in_pol_im,
  input  logic signed [31:0] in_alpha_re,
  input  logic signed [31:0] in_alpha_im,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_log_value,
  output logic signed [63:0] out_sum_value,
  output logic               out_invalid,
  output logic               out_saturated
);

  localparam int PW = $clog2(MAX_POWER + 1);

  state_t state_r, state_nxt;
  logic [4:0] pow_r;
  logic signed [15:0] xmin_r, xmax_r, ymin_r, ymax_r, zmin_r, zmax_r;
  logic signed [63:0] sum_r;
  logic sat_r;
  logic mode_r, last_r;
  logic [31:0] op_r [4];
  logic [1:0] opi_r;
  logic [63:0] sq_r;
  logic [63:0] mag_r [2];
  logic [63:0] t_r;
  logic [5:0] cnt_r;
  logic [PW-1:0] pcnt_r, n_eff;
  logic pend_r;
  // sqrt
  logic [63:0] rv_r, rres_r, rbit_r;
  // log
  logic [5:0] k_r;
  logic [63:0] m_r;
  logic [31:0] f_r;

  logic        mstart;
  logic [63:0] ma, mb;
  logic        mdone;
  logic [127:0] mprod;

  mpsl_mul u_mul (
    .clk(clk), .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mprod)
  );

  logic inbox, acc_in;
  assign inbox = (in_coord_x >= xmin_r) && (in_coord_x <= xmax_r) &&
                 (in_coord_y >= ymin_r) && (in_coord_y <= ymax_r) &&
                 (in_coord_z >= zmin_r) && (in_coord_z <= zmax_r);
  assign in_ready = (state_r == ST_IDLE);
  assign acc_in = in_valid && in_ready;

  always_comb begin
    if (pow_r == 5'd0) n_eff = PW'(1);
    else if ({27'd0, pow_r} > 32'(MAX_POWER)) n_eff = PW'(MAX_POWER);
    else n_eff = PW'(pow_r);
  end

  // multiplier operand select
  logic [31:0] abs_op;
  assign abs_op = op_r[opi_r][31] ? (32'd0 - op_r[opi_r]) : op_r[opi_r];

  always_comb begin
    unique case (state_r)
      ST_SQ:    begin ma = {32'd0, abs_op}; mb = {32'd0, abs_op}; end
      ST_MAG:   begin ma = mag_r[0];         mb = mag_r[1]; end
      ST_POW:   begin ma = t_r;              mb = m_r; end
      ST_LOGSQ: begin ma = m_r;              mb = m_r; end
      ST_LOGMUL:begin ma = {32'd0, f_r};     mb = {32'd0, LN2_Q32}; end
      default:  begin ma = '0;               mb = '0; end
    endcase
  end

  // sqrt step
  logic [63:0] rsum;
  logic        rge;
  assign rsum = rres_r + rbit_r;
  assign rge  = rv_r >= rsum;

  // sum update
  logic signed [64:0] sum_ext;
  logic [63:0] lsh;
  assign sum_ext = mode_r ? ({sum_r[63], sum_r} - {1'b0, t_r})
                          : ({sum_r[63], sum_r} + {1'b0, t_r});

  logic [63:0] msq;
  assign msq = mprod[93:30];

  // log total
  logic signed [63:0] total, uu;
  always_comb begin
    total = (64'($signed({1'b0, k_r})) - 64'sd16) * $signed({32'd0, LN2_Q32})
            + $signed({32'd0, mprod[63:32]});
    uu = total + 64'sh8000_0000_0000 + 64'sh8000;
    lsh = 64'(uu >>> 16) - 64'h8000_0000;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc_in) state_nxt = inbox ? ST_SQ : (in_last ? ST_LOGK : ST_IDLE);
      ST_SQ:    if (mdone && opi_r[0]) state_nxt = ST_SQRT;
      ST_SQRT:  if (rbit_r == 64'd0 && !pend_r) state_nxt = (opi_r == 2'd0) ? ST_MAG : ST_SQ;
      ST_MAG:   if (mdone) state_nxt = ST_POW;
      ST_POW:   if (mdone && ((mprod[127:79] != 0) || pcnt_r == PW'(1))) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_r ? ST_LOGK : ST_IDLE;
      ST_LOGK:  state_nxt = (sum_r > 0) ? ST_LOGSQ : ST_OUT;
      ST_LOGSQ: if (mdone && cnt_r == 6'd31) state_nxt = ST_LOGMUL;
      ST_LOGMUL:if (mdone) state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic first_r;
  always_comb begin
    mstart = 1'b0;
    unique case (state_r)
      ST_SQ, ST_MAG, ST_POW, ST_LOGSQ, ST_LOGMUL: mstart = first_r;
      default: mstart = 1'b0;
    endcase
  end

  logic [5:0] kk;
  always_comb begin
    kk = '0;
    for (int i = 0; i < 63; i++) if (sum_r[i]) kk = 6'(i);
  end

  assign out_valid = (state_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pow_r <= 5'd2;
      xmin_r <= '0; xmax_r <= '0; ymin_r <= '0;
      ymax_r <= '0; zmin_r <= '0; zmax_r <= '0;
      sum_r <= '0;
      sat_r <= 1'b0;
      first_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POW:  pow_r  <= cfg_data[4:0];
          REG_XMIN: xmin_r <= cfg_data;
          REG_XMAX: xmax_r <= cfg_data;
          REG_YMIN: ymin_r <= cfg_data;
          REG_YMAX: ymax_r <= cfg_data;
          REG_ZMIN: zmin_r <= cfg_data;
          REG_ZMAX: zmax_r <= cfg_data;
          default: ;
        endcase
      end
      first_r <= (state_nxt != state_r) || (mdone && state_nxt == state_r &&
                 (state_r == ST_SQ || state_r == ST_POW || state_r == ST_LOGSQ));
      if (mstart) first_r <= 1'b0;
      pend_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (acc_in) begin
          mode_r <= in_mode;
          last_r <= in_last;
          op_r[0] <= in_pol_re; op_r[1] <= in_pol_im;
          op_r[2] <= in_alpha_re; op_r[3] <= in_alpha_im;
          opi_r <= 2'd0;
          if (in_clear) begin
            sum_r <= '0;
            sat_r <= 1'b0;
          end
        end
        ST_SQ: if (mdone) begin
          if (!opi_r[0]) sq_r <= mprod[63:0];
          else begin
            rv_r <= sq_r + mprod[63:0];
            rres_r <= '0;
            rbit_r <= 64'h4000_0000_0000_0000;
            pend_r <= 1'b1;
          end
          opi_r <= opi_r + 2'd1;
        end
        ST_SQRT: if (!pend_r && rbit_r != 0) begin
          if (rge) begin
            rv_r <= rv_r - rsum;
            rres_r <= (rres_r >> 1) + rbit_r;
          end else begin
            rres_r <= rres_r >> 1;
          end
          rbit_r <= rbit_r >> 2;
        end else if (rbit_r == 0 && !pend_r) begin
          mag_r[~opi_r[1]] <= rres_r;
        end
        ST_MAG: if (mdone) begin
          m_r <= mprod[79:16];
          t_r <= 64'd65536;
          pcnt_r <= n_eff;
        end
        ST_POW: if (mdone) begin
          if (mprod[127:79] != 0) begin
            t_r <= 64'h7fff_ffff_ffff_ffff;
            sat_r <= 1'b1;
          end else t_r <= mprod[79:16];
          pcnt_r <= pcnt_r - PW'(1);
        end
        ST_ACC: begin
          if (sum_ext[64] != sum_ext[63]) begin
            sum_r <= mode_r ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
            sat_r <= 1'b1;
          end else sum_r <= sum_ext[63:0];
        end
        ST_LOGK: begin
          k_r <= kk;
          m_r <= (kk > 6'd30) ? (sum_r >> (kk - 6'd30)) : (sum_r << (6'd30 - kk));
          f_r <= '0;
          cnt_r <= '0;
          out_sum_value <= sum_r;
          out_saturated <= sat_r;
          out_invalid <= !(sum_r > 0);
          out_log_value <= '0;
        end
        ST_LOGSQ: if (mdone) begin
          cnt_r <= cnt_r + 6'd1;
          if (msq >= 64'h8000_0000) begin
            m_r <= msq >> 1;
            f_r <= {f_r[30:0], 1'b1};
          end else begin
            m_r <= msq;
            f_r <= {f_r[30:0], 1'b0};
          end
        end
        ST_LOGMUL: if (mdone) out_log_value <= lsh[31:0];
        default: ;
      endcase
    end
  end

endmodule

@@ tb/tb_masked_power_sum_log.sv @@
module tb_masked_power_sum_log;
  import mpsl_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic mode;
    logic clear;
    logic last;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic signed [31:0] pre;
    logic signed [31:0] pim;
    logic signed [31:0] are;
    logic signed [31:0] aim;
  } dipole_t;

  typedef struct packed {
    logic signed [31:0] log_value;
    logic signed [63:0] sum_value;
    logic invalid;
    logic saturated;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dipole_t in_item = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_POW;
  logic [15:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_log_value;
  logic signed [63:0] out_sum_value;
  logic out_invalid;
  logic out_saturated;

  always #4 clk = ~clk;

  masked_power_sum_log u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_item.mode), .in_clear(in_item.clear), .in_last(in_item.last),
    .in_coord_x(in_item.cx), .in_coord_y(in_item.cy), .in_coord_z(in_item.cz),
    .in_pol_re(in_item.pre), .in_pol_im(in_item.pim),
    .in_alpha_re(in_item.are), .in_alpha_im(in_item.aim),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_log_value(out_log_value), .out_sum_value(out_sum_value),
    .out_invalid(out_invalid), .out_saturated(out_saturated)
  );

  // predictor state
  logic [4:0] exp_reg = 5'd2;
  logic signed [15:0] box_lo [3];
  logic signed [15:0] box_hi [3];
  logic signed [63:0] acc_sum = '0;
  logic acc_sat = 1'b0;

  readout_t readouts_due [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bit_v;
    res = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic bit q16_product(logic [63:0] a, logic [63:0] b, output logic [63:0] r);
    logic [127:0] p;
    p = a * b;
    if (p[127:79] != 0) begin
      r = 64'h7fff_ffff_ffff_ffff;
      return 1'b0;
    end
    r = p[79:16];
    return 1'b1;
  endfunction

  function automatic logic [31:0] natural_log(logic signed [63:0] s);
    logic [63:0] v, m, fmul, u;
    logic [31:0] f;
    int k;
    logic signed [63:0] total;
    v = s;
    k = 0;
    for (int i = 0; i < 63; i++) if (v[i]) k = i;
    m = (k > 30) ? (v >> (k - 30)) : (v << (30 - k));
    f = '0;
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f[0] = 1'b1;
      end
    end
    fmul = ({32'd0, f} * {32'd0, LN2_Q32}) >> 32;
    total = (64'(k) - 64'sd16) * $signed({32'd0, LN2_Q32}) + $signed(fmul);
    u = total + (64'sd1 <<< 47);
    u = (u + 64'h8000) >> 16;
    u = u - (64'd1 << 31);
    return u[31:0];
  endfunction

  function automatic logic [63:0] abs32(logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  task automatic predict_item(dipole_t d);
    logic [63:0] mp, ma, mag, term;
    logic [4:0] n;
    readout_t r;
    logic signed [63:0] tsig;
    if (d.clear) begin
      acc_sum = '0;
      acc_sat = 1'b0;
    end
    if (d.cx >= box_lo[0] && d.cx <= box_hi[0] && d.cy >= box_lo[1] && d.cy <= box_hi[1] &&
        d.cz >= box_lo[2] && d.cz <= box_hi[2]) begin
      mp = root64(abs32(d.pre) * abs32(d.pre) + abs32(d.pim) * abs32(d.pim));
      ma = root64(abs32(d.are) * abs32(d.are) + abs32(d.aim) * abs32(d.aim));
      void'(q16_product(ma, mp, mag));
      n = (exp_reg < 1) ? 5'd1 : (exp_reg > MAX_POWER_DEF) ? 5'(MAX_POWER_DEF) : exp_reg;
      term = 64'd65536;
      for (int i = 0; i < n; i++) begin
        if (!q16_product(term, mag, term)) begin
          acc_sat = 1'b1;
          break;
        end
      end
      tsig = term;
      if (!d.mode) begin
        if (acc_sum > 64'sh7fff_ffff_ffff_ffff - tsig) begin
          acc_sum = 64'sh7fff_ffff_ffff_ffff;
          acc_sat = 1'b1;
        end else acc_sum = acc_sum + tsig;
      end else begin
        if (acc_sum < $signed(64'h8000_0000_0000_0000) + tsig) begin
          acc_sum = 64'h8000_0000_0000_0000;
          acc_sat = 1'b1;
        end else acc_sum = acc_sum - tsig;
      end
    end
    if (d.last) begin
      r.invalid = (acc_sum <= 0);
      r.log_value = r.invalid ? 32'sd0 : natural_log(acc_sum);
      r.sum_value = acc_sum;
      r.saturated = acc_sat;
      readouts_due.push_back(r);
    end
  endtask

  // receiver with random stalls and optional long hold
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (readouts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result sum=%0d", out_sum_value);
      end else begin
        readout_t e;
        e = readouts_due.pop_front();
        if (e.log_value !== out_log_value || e.sum_value !== out_sum_value ||
            e.invalid !== out_invalid || e.saturated !== out_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp log=%0d sum=%0d inv=%0b sat=%0b",
                      " got log=%0d sum=%0d inv=%0b sat=%0b"},
                     e.log_value, e.sum_value, e.invalid, e.saturated,
                     out_log_value, out_sum_value, out_invalid, out_saturated);
        end
      end
    end
  end

  task automatic send_dipole(dipole_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= d;
    in_valid <= 1'b1;
    predict_item(d);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (readouts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POW: exp_reg = val[4:0];
      REG_XMIN: box_lo[0] = val;
      REG_XMAX: box_hi[0] = val;
      REG_YMIN: box_lo[1] = val;
      REG_YMAX: box_hi[1] = val;
      REG_ZMIN: box_lo[2] = val;
      REG_ZMAX: box_hi[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_box(logic signed [15:0] lo, logic signed [15:0] hi);
    write_reg(REG_XMIN, lo); write_reg(REG_XMAX, hi);
    write_reg(REG_YMIN, lo); write_reg(REG_YMAX, hi);
    write_reg(REG_ZMIN, lo); write_reg(REG_ZMAX, hi);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(32'h0002_0000);
      2: return -$urandom_range(32'h0002_0000);
      3: return $urandom_range(32'h0001_8000, 32'h0000_8000);
      default: return $urandom_range(32'h0000_ffff);
    endcase
  endfunction

  function automatic dipole_t rand_dipole(bit inbox, bit clr, bit lst);
    dipole_t d;
    d.mode = ($urandom_range(3) == 0);
    d.clear = clr;
    d.last = lst;
    if (inbox) begin
      d.cx = 16'($urandom_range(box_hi[0] - box_lo[0]) + box_lo[0]);
      d.cy = 16'($urandom_range(box_hi[1] - box_lo[1]) + box_lo[1]);
      d.cz = 16'($urandom_range(box_hi[2] - box_lo[2]) + box_lo[2]);
    end else begin
      d.cx = 16'($urandom()); d.cy = 16'($urandom()); d.cz = 16'($urandom());
    end
    d.pre = rand_value(); d.pim = rand_value();
    d.are = rand_value(); d.aim = rand_value();
    return d;
  endfunction

  task automatic test_directed();
    dipole_t d;
    set_box(-16'sd4, 16'sd4);
    // unit magnitude, default exponent
    d = '{mode: 0, clear: 1, last: 1, cx: 0, cy: 0, cz: 0,
          pre: 32'sh10000, pim: 0, are: 32'sh10000, aim: 0};
    send_dipole(d);
    d.clear = 0; d.mode = 1; send_dipole(d);        // zero sum -> invalid
    d.mode = 1; send_dipole(d);                     // negative sum
    d.clear = 1; d.mode = 0;
    d.pre = 32'sh8000_0000; d.pim = 32'sh8000_0000;
    d.are = 32'sh8000_0000; d.aim = 32'sh8000_0000;
    send_dipole(d);                                 // term saturates
    d.clear = 0; send_dipole(d); send_dipole(d);    // sum saturates high
    d.clear = 1; d.mode = 1; send_dipole(d);
    d.clear = 0; send_dipole(d);                    // sum saturates low
    d.pre = 32'sh7fff_ffff; d.pim = 32'sh7fff_ffff;
    d.are = -32'sd1; d.aim = 32'sd1; d.clear = 1; d.mode = 0;
    send_dipole(d);
    d.cx = 16'sd5; d.clear = 0; send_dipole(d);      // outside box
    d.cx = -16'sd5; d.last = 0; send_dipole(d);
    d.cx = 16'sd4; d.cy = -16'sd4; d.cz = 16'sd4; d.last = 1; send_dipole(d);
    d.pre = 0; d.pim = 0; d.clear = 1; send_dipole(d);
    wait_drained();
    write_reg(REG_POW, 16'd0);
    d = '{mode: 0, clear: 1, last: 1, cx: 0, cy: 0, cz: 0,
          pre: 32'sh30000, pim: 32'sh40000, are: 32'sh20000, aim: 0};
    send_dipole(d);
    wait_drained();
    write_reg(REG_POW, 16'd31);
    send_dipole(d);
    d.pre = 32'sh1_1000; d.pim = 0; d.are = 32'sh1_0000; send_dipole(d);
    wait_drained();
    write_reg(REG_POW, 16'd16);
    d.pre = 32'sh0000_8000; send_dipole(d);
    wait_drained();
    set_box(16'sd3, -16'sd3);                        // empty box
    d.cx = 0; d.cy = 0; d.cz = 0; send_dipole(d);
    wait_drained();
    write_reg(3'd7, 16'hffff);                        // unused index
    set_box(16'sh8000, 16'sh7fff);
    d.cx = 16'sh8000; d.cy = 16'sh7fff; d.cz = 16'sh8000; send_dipole(d);
    d.cx = 16'sh7fff; d.cy = 16'sh8000; d.cz = 16'sh7fff; send_dipole(d);
    wait_drained();
  endtask

  task automatic random_phase(int items, int spct, int rpct);
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    for (int i = 0; i < items; i++) begin
      bit inbox;
      inbox = ($urandom_range(9) != 0);
      send_dipole(rand_dipole(inbox, $urandom_range(9) == 0, $urandom_range(3) == 0));
    end
    wait_drained();
  endtask

  task automatic test_random();
    write_reg(REG_POW, 16'd2);
    set_box(-16'sd2, 16'sd3);
    random_phase(200, 38, 75);
    write_reg(REG_POW, 16'd1);
    set_box(16'sh8000, 16'sh7fff);
    random_phase(200, 75, 38);
    write_reg(REG_POW, 16'd5);
    set_box(-16'sd100, 16'sd100);
    random_phase(350, 0, 0);
    write_reg(REG_POW, 16'd16);
    set_box(16'sd0, 16'sd0);
    random_phase(150, 38, 75);
    write_reg(REG_POW, 16'($urandom_range(31)));
    set_box(-16'sd7, 16'sd7);
    random_phase(250, 75, 38);
    write_reg(REG_POW, 16'd3);
    random_phase(300, 0, 0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_dipole(rand_dipole(1'b1, i == 0, 1'b1));
    join
    wait_drained();
    for (int i = 0; i < 10; i++) send_dipole(rand_dipole(1'b1, 1'b0, i % 2));
    wait_drained();
  endtask

  initial begin
    box_lo = '{default: '0};
    box_hi = '{default: '0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatches == 0 && readouts_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mpsl_pkg.sv
sv/mpsl_mul.sv
sv/masked_power_sum_log.sv
tb/tb_masked_power_sum_log.sv
